>>> rtl/gps_capture_host_command_responder_defines.svh
// Assertion macros shared by the RTL of the GPS capture and host command responder.
// Each macro expects clk and rst_n in scope.
`ifndef GPS_CAPTURE_HOST_COMMAND_RESPONDER_DEFINES_SVH
`define GPS_CAPTURE_HOST_COMMAND_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS
`define GCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCR_ASSERT_IMP(label, ante, cons, msg)
`define GCR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/gcr_pkg.sv
package gcr_pkg;

    // Sentence store geometry
    localparam int WRAP_LIMIT  = 50;
    localparam int STORE_DEPTH = WRAP_LIMIT + 1;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int HDR_LEN     = 6;

    // Stored spans for position replies (end is exclusive)
    localparam int LAT_FIRST = 17;
    localparam int LAT_END   = 27;
    localparam int LON_FIRST = 30;
    localparam int LON_END   = 41;

    localparam logic [7:0] MOVE_TARGET_RST = 8'd60;

    // Item kinds
    localparam logic CMD_GPS  = 1'b0;
    localparam logic CMD_HOST = 1'b1;

    // Result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_MOTION = 1'b1;

    localparam logic [2:0] DIR_STOP = 3'd0;

    // Host command codes
    localparam logic [7:0] CODE_FWD   = 8'd1;
    localparam logic [7:0] CODE_BACK  = 8'd2;
    localparam logic [7:0] CODE_LEFT  = 8'd3;
    localparam logic [7:0] CODE_RIGHT = 8'd4;
    localparam logic [7:0] CODE_STOP  = 8'd9;
    localparam logic [7:0] CODE_TEMP  = 8'd10;
    localparam logic [7:0] CODE_HUM   = 8'd11;
    localparam logic [7:0] CODE_LPG   = 8'd12;
    localparam logic [7:0] CODE_SMOKE = 8'd13;
    localparam logic [7:0] CODE_LAT   = 8'd14;
    localparam logic [7:0] CODE_LON   = 8'd15;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MOVE,
        OP_STOP,
        OP_PAIR,
        OP_LAT,
        OP_LON
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic gps_write;
        logic host_start;
        logic fetch;
        logic load;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op_in;
        logic span;
        logic slot_free;
        logic run_last;
    } ctl_stat_t;

    // Classify a host command code
    function automatic op_t decode_op(logic [7:0] code);
        op_t op;
        unique case (code) inside
            CODE_FWD, CODE_BACK, CODE_LEFT, CODE_RIGHT: op = OP_MOVE;
            CODE_STOP:                                   op = OP_STOP;
            CODE_TEMP, CODE_HUM, CODE_LPG, CODE_SMOKE:   op = OP_PAIR;
            CODE_LAT:                                    op = OP_LAT;
            CODE_LON:                                    op = OP_LON;
            default:                                     op = OP_NONE;
        endcase
        return op;
    endfunction

    // Expected GGA header character at a given position
    function automatic logic [7:0] hdr_char(logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/gcr_ctrl.sv
module gcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cmd,
    output logic              in_ready,
    input  gcr_pkg::ctl_stat_t stat,
    output gcr_pkg::ctl_cmd_t  ctl
);
    import gcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && cmd == CMD_HOST)
                begin
                    unique case (stat.op_in)
                        OP_MOVE, OP_STOP, OP_PAIR: state_next = ST_LOAD;
                        OP_LAT, OP_LON:            state_next = ST_FETCH;
                        default:                   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.slot_free)
                begin
                    if (stat.run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.span)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        ctl.gps_write  = (state_reg == ST_IDLE) && in_valid && (cmd == CMD_GPS);
        ctl.host_start = (state_reg == ST_IDLE) && in_valid && (cmd == CMD_HOST);
        ctl.fetch      = (state_reg == ST_FETCH);
        ctl.load       = (state_reg == ST_LOAD) && stat.slot_free;
    end

endmodule

>>> rtl/gcr_datapath.sv
`include "gps_capture_host_command_responder_defines.svh"

module gcr_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gcr_pkg::ctl_cmd_t  ctl,
    output gcr_pkg::ctl_stat_t stat,
    input  logic [7:0]         byte_in,
    input  logic [7:0]         temperature,
    input  logic [7:0]         humidity,
    input  logic               lpg_seen,
    input  logic               smoke_seen,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               kind,
    output logic [7:0]         reply_byte,
    output logic               last,
    output logic [2:0]         direction,
    output logic [7:0]         setpoint,
    output logic               restart_control
);
    import gcr_pkg::*;

    logic [7:0]          mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] vld_reg;

    logic [7:0]          move_target_reg;
    logic [STORE_AW-1:0] wpos_reg;
    logic [STORE_AW-1:0] wpos_next;
    logic [STORE_AW:0]   pos_inc;
    logic                hdr_bad;

    op_t                 op_reg;
    logic [7:0]          code_reg;
    logic [7:0]          val_reg;
    logic [7:0]          val_next;
    logic [STORE_AW-1:0] addr_reg;
    logic                step_reg;
    logic [7:0]          rd_data_reg;
    logic                rd_ok_reg;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [7:0]          out_reply_reg;
    logic                out_last_reg;
    logic [2:0]          out_dir_reg;
    logic [7:0]          out_sp_reg;
    logic                out_rst_reg;

    logic                kind_next;
    logic [7:0]          reply_next;
    logic [2:0]          dir_next;
    logic [7:0]          sp_next;
    logic                rst_next;

    // Decode status for the controller
    always_comb
    begin
        stat.op_in     = decode_op(byte_in);
        stat.span      = (op_reg == OP_LAT) || (op_reg == OP_LON);
        stat.slot_free = !out_valid_reg || out_ready;
        case (op_reg)
            OP_PAIR: stat.run_last = step_reg;
            OP_LAT:  stat.run_last = (addr_reg == STORE_AW'(LAT_END - 1));
            OP_LON:  stat.run_last = (addr_reg == STORE_AW'(LON_END - 1));
            default: stat.run_last = 1'b1;
        endcase
    end

    // Advance write position, drop back to zero on header mismatch or wrap
    always_comb
    begin
        pos_inc   = {1'b0, wpos_reg} + (STORE_AW + 1)'(1);
        hdr_bad   = (wpos_reg < STORE_AW'(HDR_LEN)) && (byte_in != hdr_char(wpos_reg[2:0]));
        if (hdr_bad || pos_inc > (STORE_AW + 1)'(WRAP_LIMIT))
        begin
            wpos_next = '0;
        end
        else
        begin
            wpos_next = pos_inc[STORE_AW-1:0];
        end
    end

    // Pick the sensor value for a paired reply
    always_comb
    begin
        case (byte_in)
            CODE_TEMP: val_next = temperature;
            CODE_HUM:  val_next = humidity;
            CODE_LPG:  val_next = {7'b0, lpg_seen};
            default:   val_next = {7'b0, smoke_seen};
        endcase
    end

    // Sentence store: write on GPS bytes, registered read on fetch
    always_ff @(posedge clk)
    begin
        if (ctl.gps_write)
        begin
            mem[wpos_reg] <= byte_in;
        end
        if (ctl.fetch)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            rd_ok_reg       <= 1'b0;
            wpos_reg        <= '0;
            move_target_reg <= MOVE_TARGET_RST;
            op_reg          <= OP_NONE;
            step_reg        <= 1'b0;
            addr_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                move_target_reg <= cfg_data;
            end
            if (ctl.gps_write)
            begin
                vld_reg[wpos_reg] <= 1'b1;
                wpos_reg          <= wpos_next;
            end
            if (ctl.fetch)
            begin
                rd_ok_reg <= vld_reg[addr_reg];
            end
            if (ctl.host_start)
            begin
                op_reg   <= stat.op_in;
                step_reg <= 1'b0;
                addr_reg <= (stat.op_in == OP_LON) ? STORE_AW'(LON_FIRST)
                                                   : STORE_AW'(LAT_FIRST);
            end
            else if (ctl.load)
            begin
                step_reg <= 1'b1;
                addr_reg <= addr_reg + STORE_AW'(1);
            end
            if (ctl.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the command operands
    always_ff @(posedge clk)
    begin
        if (ctl.host_start)
        begin
            code_reg <= byte_in;
            val_reg  <= val_next;
        end
    end

    // Build the next result word
    always_comb
    begin
        kind_next  = KIND_REPLY;
        reply_next = 8'd0;
        dir_next   = DIR_STOP;
        sp_next    = 8'd0;
        rst_next   = 1'b0;
        case (op_reg)
            OP_MOVE:
            begin
                kind_next = KIND_MOTION;
                dir_next  = code_reg[2:0];
                sp_next   = move_target_reg;
                rst_next  = 1'b1;
            end
            OP_STOP:
            begin
                kind_next = KIND_MOTION;
                rst_next  = 1'b1;
            end
            OP_PAIR:
            begin
                reply_next = step_reg ? code_reg : val_reg;
            end
            OP_LAT, OP_LON:
            begin
                reply_next = rd_ok_reg ? rd_data_reg : 8'd0;
            end
            default:
            begin
                reply_next = 8'd0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            out_kind_reg  <= kind_next;
            out_reply_reg <= reply_next;
            out_last_reg  <= stat.run_last;
            out_dir_reg   <= dir_next;
            out_sp_reg    <= sp_next;
            out_rst_reg   <= rst_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_kind_reg;
    assign reply_byte      = out_reply_reg;
    assign last            = out_last_reg;
    assign direction       = out_dir_reg;
    assign setpoint        = out_sp_reg;
    assign restart_control = out_rst_reg;

    `GCR_ASSERT_IMP(a_wpos_range, 1'b1, (int'(wpos_reg) <= WRAP_LIMIT), "write position past wrap")
    `GCR_ASSERT_NXT(a_hdr_reset, (ctl.gps_write && hdr_bad), (wpos_reg == '0), "header miss kept position")
    `GCR_ASSERT_NXT(a_last_mark, (ctl.load && stat.run_last), (out_last_reg && out_valid_reg), "final word not marked")
    `GCR_ASSERT_IMP(a_load_free, ctl.load, (!out_valid_reg || out_ready), "load over a pending word")

endmodule

>>> rtl/gps_capture_host_command_responder.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    cmd, byte_in, temperature, humidity, lpg_seen, smoke_seen
// out       out_valid/out_ready  kind, reply_byte, last, direction, setpoint, restart_control
// cfg       cfg_we               cfg_data (move_target)
//
// A GPS byte is accepted in the idle state and the next item can follow at once.
// Motion and sensor commands go straight to the load state; latitude and longitude replies
// read each stored byte through the registered store read (fetch state), then load it.
// Reset clears the store (per-entry valid bits), the write position and move_target to 60.
// A stalled out channel holds the result word and pauses the controller; in stays low until done.
module gps_capture_host_command_responder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] byte_in,
    input  logic [7:0] temperature,
    input  logic [7:0] humidity,
    input  logic       lpg_seen,
    input  logic       smoke_seen,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] reply_byte,
    output logic       last,
    output logic [2:0] direction,
    output logic [7:0] setpoint,
    output logic       restart_control,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);
    import gcr_pkg::*;

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    gcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    gcr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .byte_in         (byte_in),
        .temperature     (temperature),
        .humidity        (humidity),
        .lpg_seen        (lpg_seen),
        .smoke_seen      (smoke_seen),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .kind            (kind),
        .reply_byte      (reply_byte),
        .last            (last),
        .direction       (direction),
        .setpoint        (setpoint),
        .restart_control (restart_control)
    );

endmodule

>>> verif/testbench.sv
module testbench;
    import gcr_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] reply_byte;
        logic       last;
        logic [2:0] direction;
        logic [7:0] setpoint;
        logic       restart_control;
    } result_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] code;
        logic [7:0] temp;
        logic [7:0] hum;
        logic       lpg;
        logic       smoke;
        logic       typed;
        logic [1:0] n_typed;
        result_t    first;
        result_t    second;
    } stim_row_t;

    typedef enum logic [2:0] {
        HEAD_STOP,
        HEAD_FWD,
        HEAD_BACK,
        HEAD_LEFT,
        HEAD_RIGHT
    } heading_t;

    // Codes outside the decoded set
    localparam logic [7:0] CODE_NONE        = 8'd0;
    localparam logic [7:0] CODE_DIAG_FIRST  = 8'd5;
    localparam logic [7:0] CODE_DIAG_LAST   = 8'd8;
    localparam logic [7:0] CODE_UNKNOWN_LOW = 8'd16;
    localparam logic [7:0] CODE_MAX         = 8'd255;

    localparam logic [8*HDR_LEN-1:0] GGA_TAG = "$GPGGA";
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 150;
    localparam int PHASE_WORDS   = 80;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    stim_row_t  in_row = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       kind;
    logic [7:0] reply_byte;
    logic       last;
    logic [2:0] direction;
    logic [7:0] setpoint;
    logic       restart_control;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    // Predictor state
    logic [7:0] sentence_copy [STORE_DEPTH];
    int         sentence_pos;
    logic [7:0] target_copy;
    result_t    due_words [$];
    int         failures = 0;
    int         useful_words = 0;
    bit         send_quiet = 1'b0;
    stim_row_t  opening [$];

    gps_capture_host_command_responder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (in_row.cmd),
        .byte_in         (in_row.code),
        .temperature     (in_row.temp),
        .humidity        (in_row.hum),
        .lpg_seen        (in_row.lpg),
        .smoke_seen      (in_row.smoke),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .reply_byte      (reply_byte),
        .last            (last),
        .direction       (direction),
        .setpoint        (setpoint),
        .restart_control (restart_control),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("gps_capture_host_command_responder regression: fail");
        $finish;
    end

    function automatic logic [7:0] tag_char(int i);
        return GGA_TAG[8*(HDR_LEN-1-i) +: 8];
    endfunction

    function automatic result_t motion_word(heading_t d, logic [7:0] sp);
        result_t w;
        w = '0;
        w.kind = KIND_MOTION;
        w.last = 1'b1;
        w.direction = d;
        w.setpoint = sp;
        w.restart_control = 1'b1;
        return w;
    endfunction

    function automatic result_t reply_word(logic [7:0] b, logic fin);
        result_t w;
        w = '0;
        w.kind = KIND_REPLY;
        w.reply_byte = b;
        w.last = fin;
        return w;
    endfunction

    function automatic stim_row_t row_of(logic c, logic [7:0] code, logic [7:0] t,
                                         logic [7:0] h, logic l, logic s);
        stim_row_t r;
        r = '0;
        r.cmd = c;
        r.code = code;
        r.temp = t;
        r.hum = h;
        r.lpg = l;
        r.smoke = s;
        return r;
    endfunction

    function automatic stim_row_t typed_row(stim_row_t r, logic [1:0] n,
                                            result_t w0, result_t w1);
        stim_row_t t;
        t = r;
        t.typed = 1'b1;
        t.n_typed = n;
        t.first = w0;
        t.second = w1;
        return t;
    endfunction

    // Work out the words one accepted item owes, and advance the sentence copy
    task automatic respond_to(stim_row_t r);
        int p;
        if (r.cmd == CMD_GPS)
        begin
            p = sentence_pos;
            if (p < STORE_DEPTH)
                sentence_copy[p] = r.code;
            p++;
            if (p >= 1 && p <= HDR_LEN && r.code != tag_char(p - 1))
                p = 0;
            if (p > WRAP_LIMIT)
                p = 0;
            sentence_pos = p;
        end
        else
        begin
            case (r.code)
                CODE_FWD:   due_words.push_back(motion_word(HEAD_FWD, target_copy));
                CODE_BACK:  due_words.push_back(motion_word(HEAD_BACK, target_copy));
                CODE_LEFT:  due_words.push_back(motion_word(HEAD_LEFT, target_copy));
                CODE_RIGHT: due_words.push_back(motion_word(HEAD_RIGHT, target_copy));
                CODE_STOP:  due_words.push_back(motion_word(HEAD_STOP, 8'd0));
                CODE_TEMP, CODE_HUM, CODE_LPG, CODE_SMOKE:
                begin
                    case (r.code)
                        CODE_TEMP: due_words.push_back(reply_word(r.temp, 1'b0));
                        CODE_HUM:  due_words.push_back(reply_word(r.hum, 1'b0));
                        CODE_LPG:  due_words.push_back(reply_word({7'd0, r.lpg}, 1'b0));
                        default:   due_words.push_back(reply_word({7'd0, r.smoke}, 1'b0));
                    endcase
                    due_words.push_back(reply_word(r.code, 1'b1));
                end
                CODE_LAT:
                    for (int i = LAT_FIRST; i < LAT_END; i++)
                        due_words.push_back(reply_word(sentence_copy[i], i == LAT_END - 1));
                CODE_LON:
                    for (int i = LON_FIRST; i < LON_END; i++)
                        due_words.push_back(reply_word(sentence_copy[i], i == LON_END - 1));
                default: ;
            endcase
        end
    endtask

    // Check words leaving the block, predict words for items entering it
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {kind, reply_byte, last, direction, setpoint, restart_control};
                if (due_words.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: word with nothing due: kind=%0d byte=%h last=%0d",
                                 $time, got.kind, got.reply_byte, got.last);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.kind !== want.kind || got.reply_byte !== want.reply_byte
                        || got.last !== want.last || got.direction !== want.direction
                        || got.setpoint !== want.setpoint
                        || got.restart_control !== want.restart_control)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: word mismatch: expected kind=%0d byte=%h last=%0d",
                                      " dir=%0d sp=%0d rs=%0d, got kind=%0d byte=%h last=%0d",
                                      " dir=%0d sp=%0d rs=%0d"}, $time,
                                     want.kind, want.reply_byte, want.last, want.direction,
                                     want.setpoint, want.restart_control,
                                     got.kind, got.reply_byte, got.last, got.direction,
                                     got.setpoint, got.restart_control);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_row.typed)
                begin
                    if (in_row.n_typed > 0)
                        due_words.push_back(in_row.first);
                    if (in_row.n_typed > 1)
                        due_words.push_back(in_row.second);
                end
                else
                    respond_to(in_row);
            end
            if (cfg_we)
                target_copy = cfg_data;
        end
    end

    // Receiver: random stalls, quiet stretches, and two long hold-offs
    initial
    begin
        int  taken;
        int  n;
        bit  recv_quiet;
        taken = 0;
        recv_quiet = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                recv_quiet = !recv_quiet;
            if (taken == 40 || taken == 200)
                n = LONG_HOLD;
            else
                n = recv_quiet ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic offer(stim_row_t r);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_row <= r;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic offer_random(logic c, logic [7:0] code);
        if (c == CMD_GPS || (code >= CODE_FWD && code <= CODE_RIGHT)
            || (code >= CODE_STOP && code <= CODE_LON))
            useful_words++;
        offer(row_of(c, code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    // Wait for the block to drain; set_target then writes move_target
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_target(logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return 8'($urandom_range(CODE_FWD, CODE_LON));
        else if (r <= 7)
            return ($urandom_range(0, 1) != 0) ? CODE_LAT : CODE_LON;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // One random burst: sentence, host commands, noise or a broken header
    task automatic random_burst();
        int unsigned sel;
        int          len;
        int          k;
        logic [7:0]  b;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, WRAP_LIMIT) : STORE_DEPTH;
            for (int i = 0; i < len; i++)
            begin
                b = (i < HDR_LEN) ? tag_char(i) : 8'($urandom_range(0, 255));
                offer_random(CMD_GPS, b);
                if ($urandom_range(0, 7) == 0)
                    offer_random(CMD_HOST, pick_code());
            end
        end
        else if (sel <= 6)
        begin
            repeat ($urandom_range(1, 4)) offer_random(CMD_HOST, pick_code());
        end
        else if (sel == 7)
        begin
            repeat ($urandom_range(1, 3)) offer_random(CMD_GPS, 8'($urandom_range(0, 255)));
        end
        else
        begin
            k = $urandom_range(1, HDR_LEN - 1);
            for (int i = 0; i < k; i++)
                offer_random(CMD_GPS, tag_char(i));
            offer_random(CMD_GPS, tag_char(k) ^ 8'($urandom_range(1, 255)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            sentence_copy[i] = '0;
        sentence_pos = 0;
        target_copy = MOVE_TARGET_RST;

        // Directed table: position spans after reset, every code, field extremes
        opening.push_back(row_of(CMD_HOST, CODE_LAT, 8'd0, 8'd0, 1'b0, 1'b0));
        opening.push_back(row_of(CMD_HOST, CODE_LON, 8'd255, 8'd255, 1'b1, 1'b1));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_FWD, 8'd255, 8'd255, 1'b1, 1'b1),
                                    2'd1, motion_word(HEAD_FWD, MOVE_TARGET_RST), '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_BACK, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd1, motion_word(HEAD_BACK, MOVE_TARGET_RST), '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_LEFT, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd1, motion_word(HEAD_LEFT, MOVE_TARGET_RST), '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_RIGHT, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd1, motion_word(HEAD_RIGHT, MOVE_TARGET_RST), '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_STOP, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd1, motion_word(HEAD_STOP, 8'd0), '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_TEMP, 8'd255, 8'd0, 1'b0, 1'b0),
                                    2'd2, reply_word(8'd255, 1'b0),
                                    reply_word(CODE_TEMP, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_TEMP, 8'd0, 8'd255, 1'b1, 1'b1),
                                    2'd2, reply_word(8'd0, 1'b0),
                                    reply_word(CODE_TEMP, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_HUM, 8'd0, 8'd255, 1'b0, 1'b0),
                                    2'd2, reply_word(8'd255, 1'b0),
                                    reply_word(CODE_HUM, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_HUM, 8'd255, 8'd0, 1'b1, 1'b1),
                                    2'd2, reply_word(8'd0, 1'b0),
                                    reply_word(CODE_HUM, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_LPG, 8'd0, 8'd0, 1'b1, 1'b0),
                                    2'd2, reply_word(8'd1, 1'b0),
                                    reply_word(CODE_LPG, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_LPG, 8'd255, 8'd255, 1'b0, 1'b1),
                                    2'd2, reply_word(8'd0, 1'b0),
                                    reply_word(CODE_LPG, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_SMOKE, 8'd0, 8'd0, 1'b0, 1'b1),
                                    2'd2, reply_word(8'd1, 1'b0),
                                    reply_word(CODE_SMOKE, 1'b1)));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_SMOKE, 8'd255, 8'd255, 1'b1, 1'b0),
                                    2'd2, reply_word(8'd0, 1'b0),
                                    reply_word(CODE_SMOKE, 1'b1)));
        // Diagonal and unknown codes owe nothing
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_DIAG_FIRST, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd0, '0, '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_DIAG_LAST, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd0, '0, '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_NONE, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd0, '0, '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_UNKNOWN_LOW, 8'd0, 8'd0, 1'b0, 1'b0),
                                    2'd0, '0, '0));
        opening.push_back(typed_row(row_of(CMD_HOST, CODE_MAX, 8'd255, 8'd255, 1'b1, 1'b1),
                                    2'd0, '0, '0));
        // GPS bytes: wrong first byte, then a header broken at its third byte
        opening.push_back(row_of(CMD_GPS, 8'hFF, 8'd0, 8'd0, 1'b0, 1'b0));
        opening.push_back(row_of(CMD_GPS, tag_char(0), 8'd0, 8'd0, 1'b0, 1'b0));
        opening.push_back(row_of(CMD_GPS, tag_char(1), 8'd0, 8'd0, 1'b0, 1'b0));
        opening.push_back(row_of(CMD_GPS, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0));
        opening.push_back(row_of(CMD_GPS, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            offer(opening[i]);

        // Random phases, each under its own move_target
        set_target(8'd0);
        while (useful_words < PHASE_WORDS)
            random_burst();
        set_target(8'd255);
        while (useful_words < 2 * PHASE_WORDS)
            random_burst();
        set_target(8'($urandom_range(1, 254)));
        while (useful_words < 3 * PHASE_WORDS)
            random_burst();
        set_target(8'($urandom_range(0, 255)));
        while (useful_words < 4 * PHASE_WORDS)
            random_burst();

        drain();
        if (failures == 0)
            $display("gps_capture_host_command_responder regression: pass");
        else
            $display("gps_capture_host_command_responder regression: fail");
        $finish;
    end

endmodule
